FILE: rtl/core/bfc_pkg.sv
// Package for the byte frequency counter: widths, command codes, the token
// that walks the cell chain, and the saturating increment.
// No dependencies.
package bfc_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int NUM_SLOTS   = 256;
  localparam int SLOT_W      = $clog2(NUM_SLOTS);
  localparam int DIST_W      = $clog2(NUM_SLOTS + 1);
  localparam int OUT_CNT_W   = 32;

  localparam logic CMD_COUNT = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  // One command travelling down the chain, with the answer it has picked up.
  typedef struct packed {
    logic       valid;
    logic       cmd;
    logic [7:0] byte_val;
    logic [SLOT_W-1:0] slot;
    logic       done;
    logic [7:0] sym;
    logic       filled;
    logic       fresh;
    count_t     cnt;
  } bfc_tok_t;

  function automatic count_t sat_inc(input count_t v);
    count_t r;
    r = (v == '1) ? v : v + count_t'(1);
    return r;
  endfunction

  // Low 32 bits of a count, zero extended when the counter is narrower.
  function automatic logic [OUT_CNT_W-1:0] to_out(input count_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[OUT_CNT_W-1:0];
  endfunction

endpackage

FILE: rtl/core/bfc_cell.sv
// One slot of the byte histogram: symbol, count and fill flag, plus the
// registered token stage that hands the command on to the next slot.
// Depends on bfc_pkg.
module bfc_cell import bfc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic [SLOT_W-1:0] cell_idx_i,
  input  bfc_tok_t          tok_i,
  output bfc_tok_t          tok_o
);

  logic       filled_q, filled_d;
  logic [7:0] sym_q, sym_d;
  count_t     cnt_q, cnt_d;
  bfc_tok_t   tok_q, tok_d;
  count_t     cnt_inc;

  assign cnt_inc = sat_inc(cnt_q);

  always_comb begin
    filled_d = filled_q;
    sym_d    = sym_q;
    cnt_d    = cnt_q;
    tok_d    = tok_i;
    if (tok_i.valid && !tok_i.done) begin
      if (tok_i.cmd == CMD_COUNT) begin
        if (filled_q && (sym_q == tok_i.byte_val)) begin
          // known byte: bump this slot
          cnt_d        = cnt_inc;
          tok_d.done   = 1'b1;
          tok_d.slot   = cell_idx_i;
          tok_d.sym    = tok_i.byte_val;
          tok_d.filled = 1'b1;
          tok_d.cnt    = cnt_inc;
        end else if (!filled_q) begin
          // first empty slot: slots fill in order, so the byte is new
          filled_d     = 1'b1;
          sym_d        = tok_i.byte_val;
          cnt_d        = count_t'(1);
          tok_d.done   = 1'b1;
          tok_d.slot   = cell_idx_i;
          tok_d.sym    = tok_i.byte_val;
          tok_d.filled = 1'b1;
          tok_d.fresh  = 1'b1;
          tok_d.cnt    = count_t'(1);
        end
      end else if (tok_i.slot == cell_idx_i) begin
        tok_d.done   = 1'b1;
        tok_d.filled = filled_q;
        tok_d.sym    = filled_q ? sym_q : 8'd0;
        tok_d.cnt    = filled_q ? cnt_q : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= 1'b0;
      tok_q    <= '0;
    end else if (adv_i) begin
      filled_q <= filled_d;
      tok_q    <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sym_q <= sym_d;
      cnt_q <= cnt_d;
    end
  end

  assign tok_o = tok_q;

endmodule

FILE: rtl/core/byte_frequency_counter.sv
// Top level of the byte frequency counter: a chain of slot cells, the
// running totals and the result register.
// Depends on bfc_pkg and bfc_cell.
//
//  Channel   Dir  Signals                         Payload
//  s_axis    in   tvalid tready tdata[15:0] tuser  command, byte, slot to read
//  m_axis    out  tvalid tready tdata[95:0]        slot, symbol, flags, counts
//
// Each command walks the whole chain of NUM_SLOTS cells, one cell per cycle
// while the chain is not held; one command is in the chain at a time.
// A new command is taken as soon as the previous one leaves the chain, even
// while its result still waits in the output register.
// Reset clears all slot fill flags, the totals and the handshake state; no
// sweep is needed. A stalled output freezes the chain only once the next
// result reaches its tail.
module byte_frequency_counter import bfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // data_byte[7:0], read_slot[15:8]
  input  logic        s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata    // slot_index[7:0], slot_symbol[15:8],
                                      // slot_filled[16], first_seen[17],
                                      // slot_count[49:18], distinct_total[58:50],
                                      // byte_total[90:59], zero[95:91]
);

  bfc_tok_t tok [NUM_SLOTS+1];

  logic              inflight_q, inflight_d;
  logic              out_valid_q, out_valid_d;
  logic [95:0]       out_data_q, out_data_d;
  logic [DIST_W-1:0] distinct_q, distinct_d;
  count_t            bytes_q, bytes_d;
  logic              adv;
  logic              in_xfer;
  logic              out_xfer;
  logic              capture;
  bfc_tok_t          tail;

  assign tail     = tok[NUM_SLOTS];
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // Hold the chain only when a finished result has nowhere to go.
  assign adv     = !(tail.valid && out_valid_q && !m_axis_tready);
  assign capture = tail.valid && adv;

  assign s_axis_tready = !inflight_q;

  // Build the entry token straight from the transfer.
  always_comb begin
    tok[0]          = '0;
    tok[0].valid    = in_xfer;
    tok[0].cmd      = s_axis_tuser;
    tok[0].byte_val = s_axis_tdata[7:0];
    tok[0].slot     = (s_axis_tuser == CMD_READ) ? s_axis_tdata[15:8] : '0;
  end

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    bfc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .cell_idx_i (SLOT_W'(k)),
      .tok_i      (tok[k]),
      .tok_o      (tok[k+1])
    );
  end

  // Totals advance when a result leaves the chain; the result carries them.
  always_comb begin
    distinct_d  = distinct_q;
    bytes_d     = bytes_q;
    inflight_d  = inflight_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_xfer) begin
      out_valid_d = 1'b0;
    end
    if (in_xfer) begin
      inflight_d = 1'b1;
    end
    if (capture) begin
      if (tail.cmd == CMD_COUNT) begin
        bytes_d = sat_inc(bytes_q);
      end
      if (tail.fresh) begin
        distinct_d = distinct_q + DIST_W'(1);
      end
      inflight_d  = 1'b0;
      out_valid_d = 1'b1;
      out_data_d  = {5'd0, to_out(bytes_d), distinct_d, to_out(tail.cnt),
                     tail.fresh, tail.filled, tail.sym, tail.slot};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q  <= 1'b0;
      out_valid_q <= 1'b0;
      distinct_q  <= '0;
      bytes_q     <= '0;
    end else begin
      inflight_q  <= inflight_d;
      out_valid_q <= out_valid_d;
      distinct_q  <= distinct_d;
      bytes_q     <= bytes_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef ASSERT_OFF
  a_distinct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    distinct_q <= DIST_W'(NUM_SLOTS))
    else $error("distinct count beyond slot count");

  a_tail_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> inflight_q)
    else $error("token at chain tail without a command in flight");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> inflight_q && !s_axis_tready)
    else $error("chain not marked busy after a transfer");

  a_new_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[17]) |->
      (m_axis_tdata[16] && (m_axis_tdata[49:18] == 32'd1)))
    else $error("new slot without fill flag or with count other than one");

  a_count_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (capture && tail.cmd == CMD_COUNT) |-> (tail.done && tail.filled))
    else $error("count command left the chain without a slot");
`endif

endmodule

FILE: tb/bfc_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the byte frequency counter: watches both stream channels, keeps
// its own histogram of the counted bytes and compares every result transfer.
// Depends on bfc_pkg for the counter width and the command codes.
module bfc_checker import bfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [15:0] s_tdata_i,     // data_byte[7:0], read_slot[15:8]
  input  logic        s_tuser_i,     // cmd
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [95:0] m_tdata_i,     // slot_index, slot_symbol, slot_filled, first_seen,
                                     // slot_count, distinct_total, byte_total, zero pad
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          distinct_o
);

  // Packed from the top bit down, so slot_index lands in the lowest byte.
  typedef struct packed {
    logic [31:0] byte_total;
    logic [8:0]  distinct_total;
    logic [31:0] slot_count;
    logic        first_seen;
    logic        slot_filled;
    logic [7:0]  slot_symbol;
    logic [7:0]  slot_index;
  } tally_t;

  // Histogram mirror: seen map, slot assignment, per-slot counts and totals.
  logic       byte_known [NUM_SLOTS];
  logic [7:0] slot_of_sym [NUM_SLOTS];
  logic [7:0] sym_in_slot [NUM_SLOTS];
  count_t     slot_tally [NUM_SLOTS];
  logic [8:0] distinct_cnt;
  count_t     bytes_cnt;

  tally_t expected_tallies [$];
  int     errors;
  int     checked;

  // Apply one command to the mirror and return the result it must produce.
  task automatic tally_command(input logic cmd, input logic [7:0] b, input logic [7:0] rs,
                               output tally_t r);
    logic [7:0] slot;
    r = '0;
    if (cmd == CMD_COUNT) begin
      if (bytes_cnt != '1) bytes_cnt = bytes_cnt + 1'b1;
      if (byte_known[b]) begin
        slot = slot_of_sym[b];
        if (slot_tally[slot] != '1) slot_tally[slot] = slot_tally[slot] + 1'b1;
      end else begin
        slot = distinct_cnt[7:0];
        byte_known[b]     = 1'b1;
        slot_of_sym[b]    = slot;
        sym_in_slot[slot] = b;
        slot_tally[slot]  = count_t'(1);
        if (distinct_cnt < 9'd256) distinct_cnt = distinct_cnt + 1'b1;
        r.first_seen = 1'b1;
      end
      r.slot_symbol = b;
      r.slot_filled = 1'b1;
      r.slot_count  = 32'(slot_tally[slot]);
    end else begin
      slot = rs;
      // Unfilled slots read back as zero and leave the histogram alone.
      if ({1'b0, rs} < distinct_cnt) begin
        r.slot_symbol = sym_in_slot[rs];
        r.slot_filled = 1'b1;
        r.slot_count  = 32'(slot_tally[rs]);
      end
    end
    r.slot_index     = slot;
    r.distinct_total = distinct_cnt;
    r.byte_total     = 32'(bytes_cnt);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tally_t want;
    tally_t got;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        byte_known[i]  = 1'b0;
        slot_of_sym[i] = '0;
        sym_in_slot[i] = '0;
        slot_tally[i]  = '0;
      end
      distinct_cnt = '0;
      bytes_cnt    = '0;
      expected_tallies.delete();
      errors  = 0;
      checked = 0;
    end else begin
      // Compare the result transfer against the oldest prediction.
      if (m_tvalid_i && m_tready_i) begin
        if (expected_tallies.size() == 0) begin
          $error("result transfer with no command outstanding: tdata %h", m_tdata_i);
          errors++;
        end else begin
          want = expected_tallies.pop_front();
          got  = m_tdata_i[90:0];
          check_field("slot_index", want.slot_index, got.slot_index);
          check_field("slot_symbol", want.slot_symbol, got.slot_symbol);
          check_field("slot_filled", want.slot_filled, got.slot_filled);
          check_field("first_seen", want.first_seen, got.first_seen);
          check_field("slot_count", want.slot_count, got.slot_count);
          check_field("distinct_total", want.distinct_total, got.distinct_total);
          check_field("byte_total", want.byte_total, got.byte_total);
          check_field("tdata padding", 32'd0, 32'(m_tdata_i[95:91]));
          checked++;
        end
      end
      // Predict the result of each accepted command.
      if (s_tvalid_i && s_tready_i) begin
        tally_command(s_tuser_i, s_tdata_i[7:0], s_tdata_i[15:8], want);
        expected_tallies.push_back(want);
      end
    end
    fail_count_o <= errors;
    pending_o    <= expected_tallies.size();
    checked_o    <= checked;
    distinct_o   <= int'(distinct_cnt);
  end

endmodule

FILE: tb/tb_byte_frequency_counter.sv
`timescale 1ns / 1ps
// Testbench top for the byte frequency counter: clock, reset, command stimulus,
// result back-pressure and the verdict. Depends on bfc_pkg, bfc_checker and the RTL.
module tb_byte_frequency_counter;
  import bfc_pkg::*;

  // The chain takes one command at a time, and about 800 commands are sent
  // with idle gaps between them; the limit leaves ample margin.
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int DRAIN_WAIT  = 2 * (NUM_SLOTS + 1);

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // data_byte[7:0], read_slot[15:8]
  logic        s_axis_tuser = 1'b0; // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;        // slot_index[7:0], slot_symbol[15:8], slot_filled[16],
                                    // first_seen[17], slot_count[49:18],
                                    // distinct_total[58:50], byte_total[90:59]

  int fail_count;
  int pending;
  int checked;
  int distinct;

  int  count_cmds;
  int  read_cmds;
  int  cycle_count = 0;
  // Hold both sides free of idle cycles while set.
  logic no_gaps = 1'b0;

  byte_frequency_counter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  bfc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .distinct_o   (distinct)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Drop tready at random with a chance of about 9 percent, except during the quiet stretch.
  always @(posedge clk_i) begin
    m_axis_tready <= no_gaps || ($urandom_range(99) >= 9);
  end

  // Watchdog: a lost result or a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("byte_frequency_counter test failed");
      $finish;
    end
  end

  // Present one command and hold it until the transfer. An optional idle gap
  // of random length comes first, so tvalid rises at every point of the
  // chain walk; here tvalid is only lowered when such a gap follows.
  task automatic send_cmd(input logic cmd, input logic [7:0] b, input logic [7:0] rs);
    int gap;
    gap = (!no_gaps && $urandom_range(99) < 9) ? $urandom_range(1, 300) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rs, b};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (cmd == CMD_COUNT) count_cmds++;
    else read_cmds++;
  endtask

  task automatic count_byte(input logic [7:0] b);
    send_cmd(CMD_COUNT, b, 8'($urandom_range(255)));
  endtask

  task automatic read_slot(input logic [7:0] rs);
    send_cmd(CMD_READ, 8'($urandom_range(255)), rs);
  endtask

  // Hold off the sender until every outstanding result has been checked.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Mixed traffic: counts lean on a small alphabet so counts climb, with some
  // bytes from the whole range; reads mostly stay below or just past the fill boundary.
  task automatic mixed_traffic(input int n);
    logic [7:0] b;
    logic [7:0] rs;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 30) begin
        if ($urandom_range(99) < 70) rs = 8'($urandom_range((distinct < 252) ? distinct + 3 : 255));
        else rs = 8'($urandom_range(255));
        read_slot(rs);
      end else begin
        if ($urandom_range(99) < 65) b = 8'($urandom_range(11) * 23);
        else b = 8'($urandom_range(255));
        count_byte(b);
      end
    end
  endtask

  initial begin
    logic [7:0] order [NUM_SLOTS];
    logic [7:0] tmp;
    int         j;

    count_cmds = 0;
    read_cmds  = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, byte extremes, repeats, fill boundary reads.
    read_slot(8'd0);
    count_byte(8'h00);
    count_byte(8'hFF);
    count_byte(8'h00);
    count_byte(8'hA5);
    count_byte(8'h5A);
    count_byte(8'h00);
    read_slot(8'd0);
    read_slot(8'd1);
    read_slot(8'd3);
    read_slot(8'd4);
    read_slot(8'd255);
    count_byte(8'hFF);
    count_byte(8'h80);
    count_byte(8'h01);
    read_slot(8'd1);
    read_slot(8'd5);
    read_slot(8'd6);

    mixed_traffic(200);

    // Pause until the pipeline is empty, then run the quiet stretch.
    drain_results();
    no_gaps <= 1'b1;

    // Count every byte value once in shuffled order, so the table fills up
    // and the last new byte lands in slot 255.
    for (int i = 0; i < NUM_SLOTS; i++) order[i] = 8'(i);
    for (int i = NUM_SLOTS - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < NUM_SLOTS; i++) count_byte(order[i]);
    read_slot(8'd255);
    read_slot(8'd0);
    no_gaps <= 1'b0;

    // Full table: read back random slots, then more mixed traffic.
    for (int i = 0; i < 60; i++) read_slot(8'($urandom_range(255)));
    mixed_traffic(250);

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Covered %0d count and %0d read transfers, %0d results compared.",
             count_cmds, read_cmds, checked);
    $display("Distinct bytes reached %0d, with idle and stall gaps on both sides.", distinct);
    if (fail_count == 0 && pending == 0) begin
      $display("byte_frequency_counter test passed");
    end else begin
      $display("byte_frequency_counter test failed");
    end
    $finish;
  end

endmodule
